// ===== src/generational_slot_allocator_assert.svh =====
// Assertion helpers for the slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define GSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slot allocator check failed");

// Next-cycle implication, checked on aclk outside reset.
`define GSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slot allocator check failed");

`endif

// ===== src/gsa_pkg.sv =====
`timescale 1ns / 1ps

package gsa_pkg;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int GEN_W    = 32;
    localparam int LIVE_W   = 9;
    localparam int VER_W    = 32;
    localparam int STATUS_W = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - INDEX_W - GEN_W - LIVE_W - VER_W;

    // Generation memory entry: alive mark above the generation
    localparam int ENTRY_W = GEN_W + 1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch request, launch memory reads
        logic execute;   // update state, load result register
    } cmd_t;

endpackage

// ===== src/gsa_ram.sv =====
`timescale 1ns / 1ps

module gsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gsa_ctrl.sv =====
`timescale 1ns / 1ps

module gsa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output gsa_pkg::cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.execute = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid    = m_tvalid_reg;

    // Sequence: capture in idle, execute once the result register is free
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== src/gsa_datapath.sv =====
`timescale 1ns / 1ps

module gsa_datapath #(
    parameter int SLOTS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gsa_pkg::cmd_t                     cmd,
    input  logic [gsa_pkg::REQ_W-1:0]         s_tuser,
    input  logic [gsa_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic [gsa_pkg::STATUS_W-1:0]      m_tuser,
    output logic [gsa_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int XW     = (CNT_W > gsa_pkg::LIVE_W) ? CNT_W : gsa_pkg::LIVE_W;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    // Request fields at the input
    logic [gsa_pkg::INDEX_W-1:0] in_index;
    logic [XW-1:0]               in_index_ext;
    assign in_index     = s_tdata[gsa_pkg::INDEX_W-1:0];
    assign in_index_ext = XW'(in_index);

    // Latched request
    logic [gsa_pkg::REQ_W-1:0]   req_reg;
    logic [gsa_pkg::INDEX_W-1:0] index_reg;
    logic [gsa_pkg::GEN_W-1:0]   gen_reg;

    // Allocator state
    logic [CNT_W-1:0]          free_head_reg, free_head_next;
    logic [CNT_W-1:0]          high_water_reg, high_water_next;
    logic [CNT_W-1:0]          alive_reg, alive_next;
    logic [gsa_pkg::VER_W-1:0] version_reg, version_next;

    // Memory ports
    logic                        gen_we, link_we;
    logic [ADDR_W-1:0]           gen_waddr, gen_raddr, link_waddr;
    logic [gsa_pkg::ENTRY_W-1:0] gen_wdata, gen_rdata;
    logic [CNT_W-1:0]            link_rdata;

    // Result register
    logic [gsa_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [gsa_pkg::M_TDATA_W-1:0] out_reg, out_next;

    // Execute-cycle decode
    logic [XW-1:0]             index_ext, slot_ext, alive_ext;
    logic                      have_free, have_new, hit;
    logic [gsa_pkg::GEN_W-1:0] slot_gen;
    logic [CNT_W-1:0]          link_head;

    // Generation of the free head for allocate, else of the handle
    assign gen_raddr = (s_tuser == gsa_pkg::REQ_ALLOC) ? free_head_reg[ADDR_W-1:0]
                                                      : in_index_ext[ADDR_W-1:0];

    gsa_ram #(
        .WIDTH (gsa_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .aclk  (aclk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (cmd.capture),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    gsa_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (free_head_reg),
        .re    (cmd.capture),
        .raddr (free_head_reg[ADDR_W-1:0]),
        .rdata (link_rdata)
    );

    // Latch the request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= s_tuser;
            index_reg <= in_index;
            gen_reg   <= s_tdata[gsa_pkg::INDEX_W +: gsa_pkg::GEN_W];
        end
    end

    // Decode the handle and the free-list state
    assign index_ext = XW'(index_reg);
    assign have_free = free_head_reg < SLOTS_C;
    assign have_new  = high_water_reg < SLOTS_C;
    assign hit       = (index_ext < XW'(high_water_reg)) && gen_rdata[gsa_pkg::GEN_W]
                       && (gen_rdata[gsa_pkg::GEN_W-1:0] == gen_reg);
    assign link_head = (link_rdata > SLOTS_C) ? SLOTS_C : link_rdata;
    assign link_we    = cmd.execute && (req_reg == gsa_pkg::REQ_RELEASE) && hit;
    assign link_waddr = index_ext[ADDR_W-1:0];

    // Apply the request and form the result
    always_comb begin
        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;
        alive_next      = alive_reg;
        version_next    = version_reg;
        gen_we          = 1'b0;
        gen_waddr       = index_ext[ADDR_W-1:0];
        gen_wdata       = {1'b0, gen_rdata[gsa_pkg::GEN_W-1:0] + 32'd1};
        status_next     = gsa_pkg::ST_INVALID;
        slot_ext        = index_ext;
        slot_gen        = gen_reg;
        unique case (req_reg)
            gsa_pkg::REQ_ALLOC: begin
                if (have_free) begin
                    slot_ext       = XW'(free_head_reg);
                    slot_gen       = gen_rdata[gsa_pkg::GEN_W-1:0];
                    free_head_next = link_head;
                    gen_we         = cmd.execute;
                    gen_waddr      = free_head_reg[ADDR_W-1:0];
                    gen_wdata      = {1'b1, gen_rdata[gsa_pkg::GEN_W-1:0]};
                end else if (have_new) begin
                    slot_ext        = XW'(high_water_reg);
                    slot_gen        = 32'd1;
                    high_water_next = high_water_reg + CNT_W'(1);
                    gen_we          = cmd.execute;
                    gen_waddr       = high_water_reg[ADDR_W-1:0];
                    gen_wdata       = {1'b1, 32'd1};
                end
                if (have_free || have_new) begin
                    alive_next   = alive_reg + CNT_W'(1);
                    version_next = version_reg + 32'd1;
                    status_next  = gsa_pkg::ST_OK;
                end else begin
                    status_next = gsa_pkg::ST_FULL;
                end
            end
            gsa_pkg::REQ_RELEASE: begin
                if (hit) begin
                    gen_we         = cmd.execute;
                    free_head_next = CNT_W'(index_ext);
                    alive_next     = (alive_reg != '0) ? alive_reg - CNT_W'(1) : alive_reg;
                    version_next   = version_reg + 32'd1;
                    status_next    = gsa_pkg::ST_OK;
                end
            end
            gsa_pkg::REQ_CHECK: begin
                status_next = hit ? gsa_pkg::ST_OK : gsa_pkg::ST_INVALID;
            end
            default: begin
                status_next = gsa_pkg::ST_INVALID;
            end
        endcase
        alive_ext = XW'(alive_next);
        out_next  = {{gsa_pkg::M_PAD_W{1'b0}}, version_next,
                     alive_ext[gsa_pkg::LIVE_W-1:0], slot_gen,
                     slot_ext[gsa_pkg::INDEX_W-1:0]};
    end

    // Allocator state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= SLOTS_C;
            high_water_reg <= '0;
            alive_reg      <= '0;
            version_reg    <= '0;
        end else if (cmd.execute) begin
            free_head_reg  <= free_head_next;
            high_water_reg <= high_water_next;
            alive_reg      <= alive_next;
            version_reg    <= version_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            status_reg <= status_next;
            out_reg    <= out_next;
        end
    end

    assign m_tuser = status_reg;
    assign m_tdata = out_reg;

endmodule

// ===== src/generational_slot_allocator.sv =====
// Generational slot allocator: hands out (index, generation) handles from a
// pool of SLOTS slots and validates them later.
// Input stream: s_tuser carries the request kind (allocate, release, check);
// s_tdata carries the handle for release and check. Output stream: one beat
// per request, m_tuser carries the status (ok, pool full, handle invalid),
// m_tdata the handle, the live count and the structure version.
// An accepted request is latched and executes once the result register is free;
// the result beat goes valid as that register loads. The capture step reads the
// generation and free-list link memories; the execute step writes them as the
// request needs and updates the free-list head. A new request is taken once the
// previous one has executed, even while its result still waits in the output
// register.
// When the receiver stalls, the result holds in the output register and the
// next request waits after its memory read until that beat is taken.
// Reset empties the free list, zeroes the live count, the slot high-water
// mark and the version counter; no memory clearing pass is needed.
`timescale 1ns / 1ps

module generational_slot_allocator #(
    parameter int SLOTS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gsa_pkg::REQ_W-1:0]      s_tuser,   // [1:0] req_type
    input  logic [gsa_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] slot_index, [39:8] slot_generation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gsa_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    output logic [gsa_pkg::M_TDATA_W-1:0]  m_tdata    // [7:0] handle_index,
                                                      // [39:8] handle_generation,
                                                      // [48:40] live_count,
                                                      // [80:49] structure_version, rest zero
);

    gsa_pkg::cmd_t cmd;

    gsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    gsa_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tuser (m_tuser),
        .m_tdata (m_tdata)
    );

`include "generational_slot_allocator_assert.svh"

    // Busy for the execute cycle after each accepted request
    `GSA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // A new result only follows an execute cycle
    `GSA_ASSERT_NOW(a_result_after_exec, $rose(m_tvalid), $past(!s_tready))
    // Only defined status codes leave the block
    `GSA_ASSERT_NOW(a_status_code, m_tvalid,
        m_tuser == gsa_pkg::ST_OK || m_tuser == gsa_pkg::ST_FULL || m_tuser == gsa_pkg::ST_INVALID)

endmodule

// ===== test/generational_slot_allocator_checker.sv =====
`timescale 1ns / 1ps

module generational_slot_allocator_checker
    import gsa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [REQ_W-1:0]      s_tuser,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [STATUS_W-1:0]   m_tuser,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    mismatches,
    output int                    replies_owed
);

    localparam int LINK_W  = $clog2(SLOTS + 1);
    localparam int GEN_LO  = INDEX_W;
    localparam int LIVE_LO = GEN_LO + GEN_W;
    localparam int VER_LO  = LIVE_LO + LIVE_W;
    localparam int PAD_LO  = VER_LO + VER_W;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [GEN_W-1:0]    gen;
        logic [LIVE_W-1:0]   live;
        logic [VER_W-1:0]    version;
        logic [M_PAD_W-1:0]  pad;
    } reply_t;

    // Shadow of the allocator state
    logic [LINK_W-1:0] link_mem  [SLOTS];
    logic [GEN_W-1:0]  gen_mem   [SLOTS];
    logic              alive_mem [SLOTS];
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] high_mark;
    logic [LIVE_W-1:0] live_total;
    logic [VER_W-1:0]  version_ctr;

    // Replies owed, oldest first
    reply_t reply_q[$];

    task automatic clear_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            link_mem[i]  = LINK_W'(SLOTS);
            gen_mem[i]   = '0;
            alive_mem[i] = 1'b0;
        end
        free_head   = LINK_W'(SLOTS);
        high_mark   = '0;
        live_total  = '0;
        version_ctr = '0;
    endtask

    function automatic logic handle_live(input logic [INDEX_W-1:0] idx,
                                         input logic [GEN_W-1:0] gen);
        if (LINK_W'(idx) >= high_mark)
            return 1'b0;
        return alive_mem[idx] && (gen_mem[idx] == gen);
    endfunction

    // Apply one request to the shadow state and return the reply it owes
    function automatic reply_t apply_request(input logic [REQ_W-1:0] kind,
                                             input logic [INDEX_W-1:0] idx,
                                             input logic [GEN_W-1:0] gen);
        reply_t            r;
        logic [LINK_W-1:0] slot;
        logic              got;
        r         = '0;
        r.status  = ST_INVALID;
        r.index   = idx;
        r.gen     = gen;
        slot      = LINK_W'(SLOTS);
        got       = 1'b0;
        case (kind)
            REQ_ALLOC: begin
                // pop the free list first, else take a never-used slot
                if (free_head < LINK_W'(SLOTS)) begin
                    slot      = free_head;
                    free_head = link_mem[slot];
                    if (free_head > LINK_W'(SLOTS))
                        free_head = LINK_W'(SLOTS);
                    got = 1'b1;
                end else if (high_mark < LINK_W'(SLOTS)) begin
                    slot           = high_mark;
                    high_mark      = high_mark + LINK_W'(1);
                    gen_mem[slot]  = GEN_W'(1);
                    link_mem[slot] = LINK_W'(SLOTS);
                    got = 1'b1;
                end
                if (got) begin
                    alive_mem[slot] = 1'b1;
                    live_total      = live_total + LIVE_W'(1);
                    version_ctr     = version_ctr + VER_W'(1);
                    r.status        = ST_OK;
                    r.index         = slot[INDEX_W-1:0];
                    r.gen           = gen_mem[slot];
                end else begin
                    r.status = ST_FULL;
                end
            end
            REQ_RELEASE: begin
                // retire the slot, bump its generation, put it on the list
                if (handle_live(idx, gen)) begin
                    alive_mem[idx] = 1'b0;
                    gen_mem[idx]   = gen_mem[idx] + GEN_W'(1);
                    link_mem[idx]  = free_head;
                    free_head      = LINK_W'(idx);
                    if (live_total != 0)
                        live_total = live_total - LIVE_W'(1);
                    version_ctr = version_ctr + VER_W'(1);
                    r.status    = ST_OK;
                end
            end
            REQ_CHECK: begin
                r.status = handle_live(idx, gen) ? ST_OK : ST_INVALID;
            end
            default: begin
            end
        endcase
        r.live    = live_total;
        r.version = version_ctr;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, field, want, seen);
        mismatches++;
    endtask

    task automatic compare_reply(input reply_t want, input reply_t seen);
        if (seen.status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(seen.status));
        if (seen.index !== want.index)
            note_mismatch("handle_index", 64'(want.index), 64'(seen.index));
        if (seen.gen !== want.gen)
            note_mismatch("handle_generation", 64'(want.gen), 64'(seen.gen));
        if (seen.live !== want.live)
            note_mismatch("live_count", 64'(want.live), 64'(seen.live));
        if (seen.version !== want.version)
            note_mismatch("structure_version", 64'(want.version), 64'(seen.version));
        if (seen.pad !== want.pad)
            note_mismatch("tdata padding", 64'(want.pad), 64'(seen.pad));
    endtask

    // Predict on every request beat, compare on every reply beat
    always @(posedge aclk) begin : track
        reply_t want;
        reply_t seen;
        if (!aresetn) begin
            clear_shadow();
            reply_q.delete();
            replies_owed <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.status  = m_tuser;
                seen.index   = m_tdata[GEN_LO-1:0];
                seen.gen     = m_tdata[LIVE_LO-1:GEN_LO];
                seen.live    = m_tdata[VER_LO-1:LIVE_LO];
                seen.version = m_tdata[PAD_LO-1:VER_LO];
                seen.pad     = m_tdata[M_TDATA_W-1:PAD_LO];
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected reply beat: expected none, actual status %0d index %0d",
                             $time, seen.status, seen.index);
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    compare_reply(want, seen);
                end
            end
            if (s_tvalid && s_tready)
                reply_q.insert(reply_q.size(),
                               apply_request(s_tuser, s_tdata[INDEX_W-1:0],
                                             s_tdata[GEN_LO+GEN_W-1:GEN_LO]));
            replies_owed <= reply_q.size();
        end
    end

endmodule

// ===== test/generational_slot_allocator_tb.sv =====
`timescale 1ns / 1ps

module generational_slot_allocator_tb;
    import gsa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int RANDOM_REQS = 680;
    localparam int STALE_KEEP  = 32;

    typedef struct packed {
        logic [GEN_W-1:0]   gen;
        logic [INDEX_W-1:0] idx;
    } handle_t;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_MIXED } mix_e;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [REQ_W-1:0]      s_tuser;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [STATUS_W-1:0]   m_tuser;
    logic [M_TDATA_W-1:0]  m_tdata;
    int                    mismatches;
    int                    replies_owed;

    // Stimulus bookkeeping
    handle_t          live_q[$];
    handle_t          stale_q[$];
    logic [REQ_W-1:0] kinds_in_flight[$];
    int               tx_burst = 0;
    int               rx_hold  = 0;
    int               rx_quiet = 0;
    int               n_sent    = 0;
    int               n_issued  = 0;
    int               n_full    = 0;
    int               n_freed   = 0;
    int               n_refused = 0;

    always #5 aclk = ~aclk;

    generational_slot_allocator #(
        .SLOTS (256)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    generational_slot_allocator_checker #(
        .SLOTS (256)
    ) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    // Mostly short gaps, a few long ones
    function automatic int gap_draw();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Stall the reply side at random, with quiet stretches of no stall
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_quiet > 0)
                rx_quiet <= rx_quiet - 1;
            else if ($urandom_range(0, 99) < 4)
                rx_quiet <= $urandom_range(50, 200);
            else if ($urandom_range(0, 99) < 25)
                rx_hold <= gap_draw();
        end
    end

    // Latch reply beats at the edge, harvest handles between edges
    logic                 reply_seen = 1'b0;
    logic [STATUS_W-1:0]  reply_status;
    logic [M_TDATA_W-1:0] reply_data;

    always @(posedge aclk) begin
        reply_seen   <= aresetn && m_tvalid && m_tready;
        reply_status <= m_tuser;
        reply_data   <= m_tdata;
    end

    always @(negedge aclk) begin : harvest
        logic [REQ_W-1:0] kind;
        handle_t          h;
        if (reply_seen) begin
            kind = (kinds_in_flight.size() != 0) ? kinds_in_flight.pop_front() : REQ_UNKNOWN;
            h    = reply_data[$bits(handle_t)-1:0];
            if (kind == REQ_ALLOC && reply_status == ST_OK) begin
                live_q.insert(live_q.size(), h);
                n_issued++;
            end else if (kind == REQ_ALLOC && reply_status == ST_FULL) begin
                n_full++;
            end else if (kind == REQ_RELEASE && reply_status == ST_OK) begin
                n_freed++;
            end else if (reply_status == ST_INVALID) begin
                n_refused++;
            end
        end
    end

    // Present one request beat, hold it until taken, then maybe idle
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                            input logic [GEN_W-1:0] gen);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {gen, idx};
        do @(posedge aclk); while (!s_tready);
        kinds_in_flight.insert(kinds_in_flight.size(), kind);
        n_sent++;
        gap = 0;
        if (tx_burst > 0)
            tx_burst--;
        else if ($urandom_range(0, 99) < 3)
            tx_burst = $urandom_range(20, 80);
        else if ($urandom_range(0, 99) < 35)
            gap = gap_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tuser  <= REQ_W'($urandom);
            s_tdata  <= {$urandom, 8'($urandom)};
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every reply has come back
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0)
            @(posedge aclk);
    endtask

    task automatic retire(input handle_t h);
        stale_q.insert(stale_q.size(), h);
        if (stale_q.size() > STALE_KEEP)
            void'(stale_q.pop_front());
    endtask

    // Stale handle, live slot with a wrong generation, or plain noise
    function automatic handle_t bogus_handle();
        handle_t h;
        int      flavor;
        h.idx  = INDEX_W'($urandom);
        h.gen  = $urandom;
        flavor = $urandom_range(0, 3);
        if (flavor == 0 && stale_q.size() != 0) begin
            h = stale_q[$urandom_range(0, stale_q.size() - 1)];
        end else if (flavor == 1 && live_q.size() != 0) begin
            h     = live_q[$urandom_range(0, live_q.size() - 1)];
            h.gen = h.gen ^ (32'd1 << $urandom_range(0, 31));
        end else if (flavor == 2) begin
            h.gen = $urandom_range(0, 3);
        end
        return h;
    endfunction

    task automatic issue_random(input mix_e mix);
        int               roll;
        int               pick;
        int               a_w;
        int               r_w;
        int               c_w;
        int               b_w;
        int               k_w;
        handle_t          h;
        logic [REQ_W-1:0] kind;
        case (mix)
            MIX_FILL: begin
                a_w = 84; r_w = 4;  c_w = 4;  b_w = 3; k_w = 3;
            end
            MIX_DRAIN: begin
                a_w = 8;  r_w = 76; c_w = 6;  b_w = 4; k_w = 4;
            end
            default: begin
                a_w = 40; r_w = 32; c_w = 12; b_w = 7; k_w = 6;
            end
        endcase
        roll  = $urandom_range(0, 99);
        h.idx = INDEX_W'($urandom);
        h.gen = $urandom;
        if (roll < a_w || (roll < a_w + r_w + c_w && live_q.size() == 0)) begin
            kind = REQ_ALLOC;
        end else if (roll < a_w + r_w) begin
            pick = $urandom_range(0, live_q.size() - 1);
            h    = live_q[pick];
            live_q.delete(pick);
            retire(h);
            kind = REQ_RELEASE;
        end else if (roll < a_w + r_w + c_w) begin
            h    = live_q[$urandom_range(0, live_q.size() - 1)];
            kind = REQ_CHECK;
        end else if (roll < a_w + r_w + c_w + b_w) begin
            h    = bogus_handle();
            kind = REQ_RELEASE;
        end else if (roll < a_w + r_w + c_w + b_w + k_w) begin
            h    = bogus_handle();
            kind = REQ_CHECK;
        end else begin
            kind = REQ_UNKNOWN;
        end
        send_req(kind, h.idx, h.gen);
    endtask

    initial begin
        mix_e mix;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty pool, reuse through the free list, bad handles
        send_req(REQ_CHECK,   8'd0,   32'd0);
        send_req(REQ_RELEASE, 8'hFF,  32'hFFFF_FFFF);
        send_req(REQ_UNKNOWN, 8'hAA,  32'h5555_5555);
        send_req(REQ_ALLOC,   8'hFF,  32'hFFFF_FFFF);
        send_req(REQ_ALLOC,   8'h00,  32'h0000_0000);
        send_req(REQ_CHECK,   8'd0,   32'd1);
        send_req(REQ_CHECK,   8'd0,   32'd2);
        send_req(REQ_RELEASE, 8'd0,   32'd1);
        send_req(REQ_RELEASE, 8'd0,   32'd1);
        send_req(REQ_CHECK,   8'd0,   32'd1);
        send_req(REQ_ALLOC,   8'h5A,  32'hA5A5_A5A5);
        send_req(REQ_RELEASE, 8'd1,   32'hFFFF_FFFF);
        send_req(REQ_RELEASE, 8'd1,   32'd1);
        send_req(REQ_RELEASE, 8'd0,   32'd2);
        send_req(REQ_ALLOC,   8'd0,   32'd0);
        send_req(REQ_ALLOC,   8'd0,   32'd0);
        send_req(REQ_ALLOC,   8'd0,   32'd0);
        send_req(REQ_CHECK,   8'd2,   32'd1);
        send_req(REQ_CHECK,   8'd3,   32'd1);
        send_req(REQ_UNKNOWN, 8'hFF,  32'hFFFF_FFFF);
        send_req(REQ_CHECK,   8'd2,   32'd0);
        wait_for_replies();

        // Rebuild the handle pool from what the directed part left alive
        live_q.delete();
        live_q.insert(live_q.size(), handle_t'{gen: 32'd3, idx: 8'd0});
        live_q.insert(live_q.size(), handle_t'{gen: 32'd2, idx: 8'd1});
        live_q.insert(live_q.size(), handle_t'{gen: 32'd1, idx: 8'd2});
        retire('{gen: 32'd1, idx: 8'd0});
        retire('{gen: 32'd1, idx: 8'd1});
        retire('{gen: 32'd2, idx: 8'd0});

        // Random: fill to pool full, drain, then run a mixed load
        mix = MIX_FILL;
        for (int i = 0; i < RANDOM_REQS; i++) begin
            issue_random(mix);
            if (mix == MIX_FILL && n_full >= 4) begin
                wait_for_replies();
                mix = MIX_DRAIN;
            end else if (mix == MIX_DRAIN && live_q.size() <= 16) begin
                mix = MIX_MIXED;
            end
        end
        wait_for_replies();
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests: %0d handles issued, %0d pool-full replies,",
                 n_sent, n_issued, n_full);
        $display("%0d releases taken, %0d refused or invalid handles; %0d mismatches.",
                 n_freed, n_refused, mismatches);
        if (mismatches == 0)
            $display("generational_slot_allocator regression: pass");
        else
            $display("generational_slot_allocator regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d replies outstanding", $time, replies_owed);
        $display("generational_slot_allocator regression: fail");
        $finish;
    end

endmodule
